@@ rtl/core/vcc_pkg.sv @@
// Package for the vending credit controller: widths, codes, transaction types and price tables.
`default_nettype none

package vcc_pkg;

    localparam int CREDIT_BITS = 16;
    localparam int STOCK_BITS  = 8;

    localparam int OPCODE_W   = 3;
    localparam int AMOUNT_W   = 16;
    localparam int MASK_W     = 17;
    localparam int MODE_W     = 2;
    localparam int CREDIT_O_W = 16;
    localparam int STOCK_O_W  = 8;
    localparam int COST_W     = 9;
    localparam int BASE_W     = 3;
    localparam int FILL_W     = 4;

    localparam int NUM_BASE = 5;
    localparam int NUM_FILL = 12;

    // Working widths for saturating arithmetic
    localparam int SUM_W = ((CREDIT_BITS > AMOUNT_W) ? CREDIT_BITS : AMOUNT_W) + 1;
    localparam int STK_EXT_W = (STOCK_BITS > AMOUNT_W) ? STOCK_BITS : AMOUNT_W;

    localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;
    localparam logic [STOCK_BITS-1:0]  STOCK_MAX  = '1;

    localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SELECT   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REJECT   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DISPENSE = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_TAKE     = 3'd5;

    localparam logic [MODE_W-1:0] MODE_EMPTY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOCREDIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HASCREDIT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISPENSE  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [AMOUNT_W-1:0] amount;
        logic [MASK_W-1:0]   choice_mask;
    } t_in_item;

    typedef struct packed {
        logic                  accepted;
        logic [MODE_W-1:0]     mode_now;
        logic [CREDIT_O_W-1:0] credit_now;
        logic [STOCK_O_W-1:0]  stock_now;
        logic [COST_W-1:0]     chosen_cost;
        logic [BASE_W-1:0]     chosen_base;
        logic [FILL_W-1:0]     chosen_filling;
        logic                  item_handed;
    } t_out_item;

    typedef struct packed {
        logic              found;
        logic [BASE_W-1:0] base;
        logic [FILL_W-1:0] filling;
        logic [COST_W-1:0] cost;
    } t_sel;

    function automatic logic [COST_W-1:0] base_price(input logic [BASE_W-1:0] idx);
        logic [COST_W-1:0] p;
        unique case (idx)
            3'd0:    p = 9'd100;
            3'd1:    p = 9'd150;
            3'd2:    p = 9'd200;
            3'd3:    p = 9'd200;
            3'd4:    p = 9'd200;
            default: p = 9'd0;
        endcase
        return p;
    endfunction

    function automatic logic [COST_W-1:0] fill_price(input logic [FILL_W-1:0] idx);
        logic [COST_W-1:0] p;
        unique case (idx)
            4'd0:    p = 9'd20;
            4'd1:    p = 9'd50;
            4'd2:    p = 9'd50;
            4'd3:    p = 9'd50;
            4'd4:    p = 9'd50;
            4'd5:    p = 9'd50;
            4'd6:    p = 9'd100;
            4'd7:    p = 9'd20;
            4'd8:    p = 9'd70;  // cheese
            4'd9:    p = 9'd100; // cheese and ham
            4'd10:   p = 9'd20;
            4'd11:   p = 9'd50;
            default: p = 9'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/vending_credit_controller.sv @@
// Top level of the vending credit controller: input register, event logic, output register.
// A transaction taken into the input register reaches o_out_item via the output register.
// Throughput: one event per cycle unless stalled; one pass from the input register updates state.
// Both stages advance together while the output register is empty or being taken.
// Reset (synchronous, active low): mode empty, credit, stock and selection zero, no item waiting,
// both pipeline registers empty.
`default_nettype none

module vending_credit_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire vcc_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output vcc_pkg::t_out_item     o_out_item
);

    logic               r_in_valid;
    vcc_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    vcc_pkg::t_out_item r_out_item;

    logic               advance;
    logic               fire;
    logic               in_take;
    vcc_pkg::t_sel      sel;
    vcc_pkg::t_out_item result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    vcc_sel_decode u_sel_decode (
        .i_choice_mask (r_in_item.choice_mask),
        .o_sel         (sel)
    );

    vcc_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_sel    (sel),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ rtl/core/vcc_sel_decode.sv @@
// Selection decode: lowest base and filling bits and the summed price.
`default_nettype none

module vcc_sel_decode (
    input  wire logic [vcc_pkg::MASK_W-1:0] i_choice_mask,
    output vcc_pkg::t_sel                   o_sel
);

    logic [vcc_pkg::NUM_BASE-1:0] base_bits;
    logic [vcc_pkg::NUM_FILL-1:0] fill_bits;
    logic [vcc_pkg::BASE_W-1:0]   base_idx;
    logic [vcc_pkg::FILL_W-1:0]   fill_idx;

    assign base_bits = i_choice_mask[vcc_pkg::NUM_BASE-1:0];
    assign fill_bits = i_choice_mask[vcc_pkg::MASK_W-1:vcc_pkg::NUM_BASE];

    always_comb begin
        base_idx = '0;
        for (int i = vcc_pkg::NUM_BASE - 1; i >= 0; i--) begin
            if (base_bits[i]) begin
                base_idx = vcc_pkg::BASE_W'(i);
            end
        end
    end

    always_comb begin
        fill_idx = '0;
        for (int i = vcc_pkg::NUM_FILL - 1; i >= 0; i--) begin
            if (fill_bits[i]) begin
                fill_idx = vcc_pkg::FILL_W'(i);
            end
        end
    end

    assign o_sel.found   = (|base_bits) && (|fill_bits);
    assign o_sel.base    = base_idx;
    assign o_sel.filling = fill_idx;
    assign o_sel.cost    = vcc_pkg::base_price(base_idx) + vcc_pkg::fill_price(fill_idx);

endmodule

`default_nettype wire

@@ rtl/core/vcc_state.sv @@
// Controller state registers and per-event next-state and result logic.
`default_nettype none

module vcc_state (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire vcc_pkg::t_in_item i_item,
    input  wire vcc_pkg::t_sel     i_sel,
    output vcc_pkg::t_out_item     o_result
);

    logic [vcc_pkg::MODE_W-1:0]      r_mode, n_mode;
    logic [vcc_pkg::CREDIT_BITS-1:0] r_credit, n_credit;
    logic [vcc_pkg::STOCK_BITS-1:0]  r_stock, n_stock;
    logic [vcc_pkg::COST_W-1:0]      r_sel_cost, n_sel_cost;
    logic [vcc_pkg::BASE_W-1:0]      r_sel_base, n_sel_base;
    logic [vcc_pkg::FILL_W-1:0]      r_sel_filling, n_sel_filling;
    logic                            r_item_waiting, n_item_waiting;

    logic                            ok;
    logic                            handed;
    logic [vcc_pkg::SUM_W-1:0]       amt_ext, crd_ext, cmax_ext, sum_ext, cost_ext;
    logic [vcc_pkg::SUM_W-1:0]       credit_now_ext;
    logic [vcc_pkg::STK_EXT_W-1:0]   amt_stk, smax_stk, stock_now_ext;
    logic [vcc_pkg::STOCK_BITS-1:0]  stock_dec;
    logic [vcc_pkg::CREDIT_BITS-1:0] credit_ins_new, credit_ins_add;

    assign amt_ext  = vcc_pkg::SUM_W'(i_item.amount);
    assign crd_ext  = vcc_pkg::SUM_W'(r_credit);
    assign cmax_ext = vcc_pkg::SUM_W'(vcc_pkg::CREDIT_MAX);
    assign sum_ext  = crd_ext + amt_ext;
    assign cost_ext = vcc_pkg::SUM_W'(i_sel.cost);

    assign credit_ins_new = (amt_ext > cmax_ext) ? vcc_pkg::CREDIT_MAX
                                                 : vcc_pkg::CREDIT_BITS'(amt_ext);
    assign credit_ins_add = (sum_ext > cmax_ext) ? vcc_pkg::CREDIT_MAX
                                                 : vcc_pkg::CREDIT_BITS'(sum_ext);

    assign amt_stk   = vcc_pkg::STK_EXT_W'(i_item.amount);
    assign smax_stk  = vcc_pkg::STK_EXT_W'(vcc_pkg::STOCK_MAX);
    assign stock_dec = (r_stock == '0) ? '0 : r_stock - vcc_pkg::STOCK_BITS'(1);

    always_comb begin
        n_mode         = r_mode;
        n_credit       = r_credit;
        n_stock        = r_stock;
        n_sel_cost     = r_sel_cost;
        n_sel_base     = r_sel_base;
        n_sel_filling  = r_sel_filling;
        n_item_waiting = r_item_waiting;
        ok             = 1'b0;
        handed         = 1'b0;
        unique case (i_item.opcode)
            vcc_pkg::OP_INSERT: begin
                if (r_mode == vcc_pkg::MODE_NOCREDIT) begin
                    n_credit = credit_ins_new;
                    n_mode   = vcc_pkg::MODE_HASCREDIT;
                    ok       = 1'b1;
                end else if (r_mode == vcc_pkg::MODE_HASCREDIT) begin
                    n_credit = credit_ins_add;
                    ok       = 1'b1;
                end
            end
            vcc_pkg::OP_SELECT: begin
                if (r_mode == vcc_pkg::MODE_HASCREDIT) begin
                    n_item_waiting = 1'b0;
                    if (i_sel.found) begin
                        n_sel_base    = i_sel.base;
                        n_sel_filling = i_sel.filling;
                        n_sel_cost    = i_sel.cost;
                        if (cost_ext <= crd_ext) begin
                            n_credit = vcc_pkg::CREDIT_BITS'(crd_ext - cost_ext);
                            n_mode   = vcc_pkg::MODE_DISPENSE;
                            ok       = 1'b1;
                        end
                    end
                end
            end
            vcc_pkg::OP_REJECT: begin
                if (r_mode == vcc_pkg::MODE_EMPTY) begin
                    n_credit = '0;
                    ok       = 1'b1;
                end else if (r_mode == vcc_pkg::MODE_HASCREDIT) begin
                    n_credit = '0;
                    n_mode   = vcc_pkg::MODE_NOCREDIT;
                    ok       = 1'b1;
                end
            end
            vcc_pkg::OP_LOAD: begin
                if (r_mode == vcc_pkg::MODE_EMPTY) begin
                    n_stock = (amt_stk > smax_stk) ? vcc_pkg::STOCK_MAX
                                                   : vcc_pkg::STOCK_BITS'(amt_stk);
                    n_mode  = vcc_pkg::MODE_NOCREDIT;
                    ok      = 1'b1;
                end
            end
            vcc_pkg::OP_DISPENSE: begin
                if (r_mode == vcc_pkg::MODE_DISPENSE) begin
                    n_stock = stock_dec;
                    if (stock_dec == '0) begin
                        n_credit = '0;
                        n_mode   = vcc_pkg::MODE_EMPTY;
                    end else if (r_credit == '0) begin
                        n_mode = vcc_pkg::MODE_NOCREDIT;
                    end else begin
                        n_mode = vcc_pkg::MODE_HASCREDIT;
                    end
                    n_item_waiting = 1'b1;
                    ok             = 1'b1;
                end
            end
            vcc_pkg::OP_TAKE: begin
                if (r_item_waiting) begin
                    n_item_waiting = 1'b0;
                    handed         = 1'b1;
                    ok             = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign credit_now_ext = vcc_pkg::SUM_W'(n_credit);
    assign stock_now_ext  = vcc_pkg::STK_EXT_W'(n_stock);

    assign o_result.accepted       = ok;
    assign o_result.mode_now       = n_mode;
    assign o_result.credit_now     = credit_now_ext[vcc_pkg::CREDIT_O_W-1:0];
    assign o_result.stock_now      = stock_now_ext[vcc_pkg::STOCK_O_W-1:0];
    assign o_result.chosen_cost    = n_sel_cost;
    assign o_result.chosen_base    = n_sel_base;
    assign o_result.chosen_filling = n_sel_filling;
    assign o_result.item_handed    = handed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= vcc_pkg::MODE_EMPTY;
            r_credit       <= '0;
            r_stock        <= '0;
            r_sel_cost     <= '0;
            r_sel_base     <= '0;
            r_sel_filling  <= '0;
            r_item_waiting <= 1'b0;
        end else if (i_fire) begin
            r_mode         <= n_mode;
            r_credit       <= n_credit;
            r_stock        <= n_stock;
            r_sel_cost     <= n_sel_cost;
            r_sel_base     <= n_sel_base;
            r_sel_filling  <= n_sel_filling;
            r_item_waiting <= n_item_waiting;
        end
    end

    // Without credit the balance is always zero
    a_no_credit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == vcc_pkg::MODE_EMPTY || r_mode == vcc_pkg::MODE_NOCREDIT)
        |-> (r_credit == '0))
        else $error("credit held outside credit modes");

    // Dispensing only follows a recorded, priced selection
    a_dispense_has_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == vcc_pkg::MODE_DISPENSE) |-> (r_sel_cost != '0))
        else $error("dispensing without a selection");

    a_dispense_sets_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.opcode == vcc_pkg::OP_DISPENSE
         && r_mode == vcc_pkg::MODE_DISPENSE) |=> r_item_waiting)
        else $error("item not marked waiting after dispense");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.opcode == vcc_pkg::OP_TAKE) |=> !r_item_waiting)
        else $error("item still waiting after take");

endmodule

`default_nettype wire

@@ tb/vending_credit_controller_checker.sv @@
// Checker for the vending credit controller: tracks the machine state, predicts each result and compares.
`timescale 1ns / 1ps

module vending_credit_controller_checker
    import vcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked,
    output int        o_carried
);

    localparam int EXP_DEPTH = 16;

    logic [MODE_W-1:0]      mode_q;
    logic [CREDIT_BITS-1:0] credit_q;
    logic [STOCK_BITS-1:0]  stock_q;
    logic [COST_W-1:0]      cost_q;
    logic                   sel_q;
    logic [BASE_W-1:0]      base_q;
    logic [FILL_W-1:0]      fill_q;
    logic                   waiting_q;

    t_out_item receipt_mem [EXP_DEPTH];
    int        receipt_wr = 0;
    int        receipt_rd = 0;
    t_out_item want;

    function automatic logic [COST_W-1:0] bread_cost(int idx);
        case (idx)
            0:       return 9'd100;
            1:       return 9'd150;
            default: return 9'd200;
        endcase
    endfunction

    function automatic logic [COST_W-1:0] filling_cost(int idx);
        case (idx)
            0, 7, 10: return 9'd20;
            6, 9:     return 9'd100;
            8:        return 9'd70;
            default:  return 9'd50;
        endcase
    endfunction

    // Applies one event to the tracked state and returns the result it should give.
    function automatic t_out_item vend_event(t_in_item ev);
        t_out_item  r;
        logic [32:0] wide;
        int b;
        int f;
        int i;
        r = '0;
        b = NUM_BASE;
        f = NUM_FILL;
        case (ev.opcode)
            OP_INSERT: begin
                if (mode_q == MODE_NOCREDIT || mode_q == MODE_HASCREDIT) begin
                    wide = 33'(ev.amount);
                    if (mode_q == MODE_HASCREDIT)
                        wide = wide + 33'(credit_q);
                    credit_q = (wide > 33'(CREDIT_MAX)) ? CREDIT_MAX : CREDIT_BITS'(wide);
                    mode_q = MODE_HASCREDIT;
                    r.accepted = 1'b1;
                end
            end
            OP_SELECT: begin
                if (mode_q == MODE_HASCREDIT) begin
                    waiting_q = 1'b0;
                    for (i = NUM_BASE - 1; i >= 0; i--)
                        if (ev.choice_mask[i]) b = i;
                    for (i = NUM_FILL - 1; i >= 0; i--)
                        if (ev.choice_mask[NUM_BASE + i]) f = i;
                    if (b < NUM_BASE && f < NUM_FILL) begin
                        base_q = BASE_W'(b);
                        fill_q = FILL_W'(f);
                        cost_q = bread_cost(b) + filling_cost(f);
                        sel_q  = 1'b1;
                        if (33'(cost_q) <= 33'(credit_q)) begin
                            credit_q = credit_q - CREDIT_BITS'(cost_q);
                            mode_q = MODE_DISPENSE;
                            r.accepted = 1'b1;
                        end
                    end
                end
            end
            OP_REJECT: begin
                if (mode_q == MODE_EMPTY || mode_q == MODE_HASCREDIT) begin
                    credit_q = '0;
                    if (mode_q == MODE_HASCREDIT)
                        mode_q = MODE_NOCREDIT;
                    r.accepted = 1'b1;
                end
            end
            OP_LOAD: begin
                if (mode_q == MODE_EMPTY) begin
                    stock_q = (ev.amount > AMOUNT_W'(STOCK_MAX)) ? STOCK_MAX
                                                                : STOCK_BITS'(ev.amount);
                    mode_q = MODE_NOCREDIT;
                    r.accepted = 1'b1;
                end
            end
            OP_DISPENSE: begin
                if (mode_q == MODE_DISPENSE) begin
                    if (stock_q != '0)
                        stock_q = stock_q - 1'b1;
                    if (stock_q == '0) begin
                        credit_q = '0;
                        mode_q = MODE_EMPTY;
                    end else if (credit_q == '0) begin
                        mode_q = MODE_NOCREDIT;
                    end else begin
                        mode_q = MODE_HASCREDIT;
                    end
                    waiting_q = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_TAKE: begin
                if (waiting_q) begin
                    waiting_q = 1'b0;
                    r.item_handed = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.mode_now       = mode_q;
        r.credit_now     = CREDIT_O_W'(credit_q);
        r.stock_now      = STOCK_O_W'(stock_q);
        r.chosen_cost    = sel_q ? cost_q : '0;
        r.chosen_base    = sel_q ? base_q : '0;
        r.chosen_filling = sel_q ? fill_q : '0;
        return r;
    endfunction

    task automatic flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q     = MODE_EMPTY;
            credit_q   = '0;
            stock_q    = '0;
            cost_q     = '0;
            sel_q      = 1'b0;
            base_q     = '0;
            fill_q     = '0;
            waiting_q  = 1'b0;
            receipt_wr = 0;
            receipt_rd = 0;
            o_errors   = 0;
            o_checked  = 0;
            o_carried  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (receipt_wr == receipt_rd) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, i_out_item);
                    o_errors++;
                end else begin
                    want = receipt_mem[receipt_rd % EXP_DEPTH];
                    receipt_rd++;
                    o_checked++;
                    if (want.accepted)
                        o_carried++;
                    if (i_out_item !== want) begin
                        o_errors++;
                        flag_field("accepted", want.accepted, i_out_item.accepted);
                        flag_field("mode_now", want.mode_now, i_out_item.mode_now);
                        flag_field("credit_now", want.credit_now, i_out_item.credit_now);
                        flag_field("stock_now", want.stock_now, i_out_item.stock_now);
                        flag_field("chosen_cost", want.chosen_cost, i_out_item.chosen_cost);
                        flag_field("chosen_base", want.chosen_base, i_out_item.chosen_base);
                        flag_field("chosen_filling", want.chosen_filling,
                                   i_out_item.chosen_filling);
                        flag_field("item_handed", want.item_handed, i_out_item.item_handed);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (receipt_wr - receipt_rd >= EXP_DEPTH) begin
                    $display("%0t: too many transactions in flight, expected at most %0d, got %0d",
                             $time, EXP_DEPTH, receipt_wr - receipt_rd + 1);
                    o_errors++;
                end
                receipt_mem[receipt_wr % EXP_DEPTH] = vend_event(i_in_item);
                receipt_wr++;
            end
        end
        o_pending = receipt_wr - receipt_rd;
    end

endmodule

@@ tb/vending_credit_controller_tb.sv @@
// Testbench top for the vending credit controller: clock, reset, event stimulus and verdict.
`timescale 1ns / 1ps

module vending_credit_controller_tb;
    import vcc_pkg::*;

    localparam int TOTAL_EVENTS = 1125;

    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int errors;
    int pending;
    int checked;
    int carried;
    int sent = 0;
    int directed = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    always #1 clk = ~clk;

    vending_credit_controller i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    vending_credit_controller_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_carried  (carried)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic set_phase(int p);
        case (p)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 52; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 36; stall_pct = 36; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_event(logic [OPCODE_W-1:0] op, logic [AMOUNT_W-1:0] amt,
                              logic [MASK_W-1:0] mask);
        t_in_item ev;
        ev.opcode      = op;
        ev.amount      = amt;
        ev.choice_mask = mask;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Random event now and then, covering unused opcodes and arbitrary fields.
    task automatic shop_event(logic [OPCODE_W-1:0] op, logic [AMOUNT_W-1:0] amt,
                              logic [MASK_W-1:0] mask);
        if ($urandom_range(0, 9) == 0)
            send_event(OPCODE_W'($urandom_range(0, 7)), AMOUNT_W'($urandom),
                       MASK_W'($urandom));
        send_event(op, amt, mask);
    endtask

    function automatic logic [MASK_W-1:0] make_choice();
        logic [NUM_BASE-1:0] bases;
        logic [NUM_FILL-1:0] fills;
        int b;
        int f;
        b = $urandom_range(0, NUM_BASE - 1);
        f = $urandom_range(0, NUM_FILL - 1);
        bases = (NUM_BASE'($urandom) << b) | (NUM_BASE'(1) << b);
        fills = (NUM_FILL'($urandom) << f) | (NUM_FILL'(1) << f);
        case ($urandom_range(0, 15))
            0:       bases = '0;
            1:       fills = '0;
            2:       return MASK_W'($urandom);
            default: ;
        endcase
        return {fills, bases};
    endfunction

    function automatic logic [AMOUNT_W-1:0] coin_amount();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return AMOUNT_W'($urandom);
            2:       return '0;
            default: return AMOUNT_W'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [AMOUNT_W-1:0] stock_amount();
        case ($urandom_range(0, 9))
            0:       return AMOUNT_W'($urandom);
            1:       return AMOUNT_W'($urandom_range(255, 256));
            default: return AMOUNT_W'($urandom_range(0, 6));
        endcase
    endfunction

    initial begin
        #400000;
        $display("[vending_credit_controller] ERROR");
        $finish;
    end

    initial begin
        set_phase(0);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // events in the empty state; only the reject is accepted
        send_event(OP_TAKE, 16'd0, 17'h00000);
        send_event(OP_INSERT, 16'd5, 17'h00000);
        send_event(OP_REJECT, 16'd0, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h1FFFF);
        send_event(OP_DISPENSE, 16'd0, 17'h00000);
        // zero stock, zero money, incomplete choices
        send_event(OP_LOAD, 16'd0, 17'h00000);
        send_event(OP_INSERT, 16'd0, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h0001F);
        send_event(OP_SELECT, 16'd0, 17'h00020);
        // credit saturation, cheese, dispense with no stock
        send_event(OP_INSERT, 16'hFFFF, 17'h00000);
        send_event(OP_INSERT, 16'hFFFF, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h02001);
        send_event(OP_DISPENSE, 16'd0, 17'h00000);
        // stock saturation, hand over, short credit, cheese and ham
        send_event(OP_LOAD, 16'hFFFF, 17'h00000);
        send_event(OP_TAKE, 16'd0, 17'h00000);
        send_event(OP_INSERT, 16'd300, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h1FFFF);
        send_event(OP_DISPENSE, 16'd0, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h04010);
        send_event(OP_TAKE, 16'd0, 17'h00000);
        send_event(OP_SPARE_LO, 16'hA5A5, 17'h15A5A);
        send_event(OP_SPARE_HI, 16'h5A5A, 17'h0A5A5);
        send_event(OP_REJECT, 16'd0, 17'h00000);
        // exact credit leaves zero, dispense drops to no credit
        send_event(OP_INSERT, 16'd250, 17'h00000);
        send_event(OP_SELECT, 16'd0, 17'h00802);
        send_event(OP_DISPENSE, 16'd0, 17'h00000);
        directed = sent;

        while (sent < TOTAL_EVENTS) begin
            set_phase((sent - directed) * 4 / (TOTAL_EVENTS - directed));
            shop_event(OP_LOAD, stock_amount(), MASK_W'($urandom));
            repeat ($urandom_range(1, 4)) begin
                shop_event(OP_INSERT, coin_amount(), MASK_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    shop_event(OP_INSERT, coin_amount(), MASK_W'($urandom));
                if ($urandom_range(0, 7) == 0)
                    shop_event(OP_REJECT, AMOUNT_W'($urandom), MASK_W'($urandom));
                shop_event(OP_SELECT, AMOUNT_W'($urandom), make_choice());
                shop_event(OP_DISPENSE, AMOUNT_W'($urandom), MASK_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    shop_event(OP_TAKE, AMOUNT_W'($urandom), MASK_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Summary: %0d events sent (%0d directed), %0d results checked, %0d carried out.",
                 sent, directed, checked, carried);
        $display("Summary: ran free flow, sender gaps, receiver stalls and both together.");
        if (errors == 0)
            $display("[vending_credit_controller] OK");
        else
            $display("[vending_credit_controller] ERROR");
        $finish;
    end

endmodule
